// ===== sv/hlrv_pkg.sv =====
// Shared types and constants for the historical log-return volatility block.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package hlrv_pkg;

  // Series length limit and the width of the price counter that follows from it
  localparam int MAX_SAMPLES = 65536;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

  // ln(2) in Q0.32
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  // Reset value of the time step register (Q0.32 years)
  localparam logic [31:0] TIME_STEP_RESET = 32'd17043521;

  // Configuration register index (byte address bit 2)
  localparam logic REG_TIME_STEP = 1'b0;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;

  // Input item
  typedef struct packed {
    logic [31:0] price;
    logic        last;
  } price_item_t;

  // Result item
  typedef struct packed {
    logic [31:0] volatility;
    logic [1:0]  status;
  } vol_result_t;

  // Item as classified by the front queue
  typedef struct packed {
    logic [31:0] price;
    logic        last;
    logic        is_zero;
  } front_item_t;

  // Request to the shared long divider
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
    logic [31:0] rem_init;
  } div_req_t;

endpackage
`default_nettype wire

// ===== sv/hlrv_front.sv =====
// Front queue: takes input items, tags zero prices, and holds them for the engine.
// Depends on hlrv_pkg.
`default_nettype none
module hlrv_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire hlrv_pkg::price_item_t item,
  output logic                     q_valid,
  output hlrv_pkg::front_item_t    q_item,
  input  wire logic                q_pop
);
  import hlrv_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  front_item_t            mem [DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [PTR_W:0]         count;
  logic                   do_push;
  logic                   do_pop;

  assign full    = (count == (PTR_W+1)'(DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

  // Storage with zero-price tag
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= '{price: item.price, last: item.last, is_zero: (item.price == '0)};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= (PTR_W+1)'(DEPTH))
    else $error("front queue overfilled");
  assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("front queue lost a push");
  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !q_valid)
    else $error("front queue shows an item while empty");

endmodule
`default_nettype wire

// ===== sv/hlrv_div.sv =====
// Shared restoring divider: 64-bit dividend, 32-bit divisor, one quotient bit a cycle.
// Depends on hlrv_pkg.
`default_nettype none
module hlrv_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire hlrv_pkg::div_req_t req,
  output logic                    busy,
  output logic                    done,
  output logic [63:0]             quot
);
  import hlrv_pkg::*;

  logic [5:0]  cnt;
  logic [63:0] dvd;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [32:0] rem_sh;
  logic        ge;
  logic [31:0] rem_next;

  // One restoring step
  always_comb begin
    rem_sh   = {rem, dvd[63]};
    ge       = (rem_sh >= {1'b0, dsr});
    rem_next = ge ? 32'(rem_sh - {1'b0, dsr}) : rem_sh[31:0];
  end

  assign quot = dvd;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      rem <= req.rem_init;
      dsr <= req.divisor;
    end else if (busy) begin
      dvd <= {dvd[62:0], ge};
      rem <= rem_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a run");
  assert property (@(posedge clk) disable iff (rst) req.start |=> busy)
    else $error("divider did not start");

endmodule
`default_nettype wire

// ===== sv/hlrv_engine.sv =====
// Back end: log returns, Welford update, final variance scaling and square root.
// Depends on hlrv_pkg; uses the shared divider through its request struct.
`default_nettype none
module hlrv_engine (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  input  wire hlrv_pkg::front_item_t q_item,
  output logic                       q_pop,
  input  wire logic [31:0]           time_step,
  output hlrv_pkg::div_req_t         div_req,
  input  wire logic                  div_busy,
  input  wire logic                  div_done,
  input  wire logic [63:0]           div_quot,
  output logic                       empty,
  output hlrv_pkg::vol_result_t      result,
  input  wire logic                  pop
);
  import hlrv_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOG   = 4'd1;
  localparam logic [3:0] S_LOGD  = 4'd2;
  localparam logic [3:0] S_RET1  = 4'd3;
  localparam logic [3:0] S_RET2  = 4'd4;
  localparam logic [3:0] S_DELTA = 4'd5;
  localparam logic [3:0] S_SQ1   = 4'd6;
  localparam logic [3:0] S_SQ2   = 4'd7;
  localparam logic [3:0] S_DIV1  = 4'd8;
  localparam logic [3:0] S_DIV2  = 4'd9;
  localparam logic [3:0] S_END   = 4'd10;
  localparam logic [3:0] S_VAR   = 4'd11;
  localparam logic [3:0] S_CHK   = 4'd12;
  localparam logic [3:0] S_RAD   = 4'd13;
  localparam logic [3:0] S_SQRT  = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0]        state;
  logic [4:0]        cnt;
  logic [CNT_W-1:0]  sample_count;
  logic [CNT_W-1:0]  k;
  logic              last_r;
  logic              zero_seen;
  logic [36:0]       prev_log;
  logic [4:0]        log_e;
  logic [31:0]       log_frac;
  logic [31:0]       m;
  logic              dneg;
  logic [36:0]       dmag;
  logic [63:0]       prod;
  logic [39:0]       r;
  logic [39:0]       mean_return;
  logic [63:0]       sum_sq_dev;
  logic              dsign;
  logic [40:0]       dabs;
  logic [63:0]       p0;
  logic [40:0]       p1;
  logic [17:0]       p2;
  logic [63:0]       sq;
  logic [40:0]       step;
  logic [63:0]       var_q;
  logic [63:0]       rad;
  logic [34:0]       srem;
  logic [31:0]       root;
  logic [31:0]       vol;
  logic [1:0]        st;
  logic              res_valid;
  vol_result_t       res;

  // Combinational helpers
  logic [4:0]        lead;
  logic [31:0]       m_init;
  logic [63:0]       msq;
  logic [32:0]       mt;
  logic [36:0]       cur_log;
  logic [37:0]       d;
  logic [37:0]       rmag;
  logic [40:0]       delta;
  logic [63:0]       add;
  logic [64:0]       sum_ext;
  logic [34:0]       s_sh;
  logic [34:0]       s_trial;
  logic              s_ge;
  logic [31:0]       root_next;
  logic              out_fire;
  logic              take;

  // Leading one of the incoming price
  always_comb begin
    lead = '0;
    for (int i = 0; i < 32; i++) begin
      if (q_item.price[i]) lead = 5'(i);
    end
    m_init = q_item.price << (5'd31 - lead);
  end

  // One log2 fraction bit by squaring the mantissa
  always_comb begin
    msq = 64'(m) * 64'(m);
    mt  = msq[63:31];
  end

  always_comb begin
    cur_log = {log_e, log_frac};
    d       = {1'b0, cur_log} - {1'b0, prev_log};
    rmag    = 38'(dmag[36:32]) * 38'(LN2_Q32) + 38'(prod[63:32]);
    delta   = {r[39], r} - {mean_return[39], mean_return};
    add     = sq - div_quot;
    sum_ext = {1'b0, sum_sq_dev} + {1'b0, add};
  end

  // One square root step
  always_comb begin
    s_sh      = {srem[32:0], rad[63:62]};
    s_trial   = {1'b0, root, 2'b01};
    s_ge      = (s_sh >= s_trial);
    root_next = {root[30:0], s_ge};
  end

  assign take     = (state == S_IDLE) && q_valid;
  assign q_pop    = take;
  assign out_fire = (state == S_OUT) && (!res_valid || pop);
  assign empty    = !res_valid;
  assign result   = res;

  // Divider requests
  always_comb begin
    div_req = '{start: 1'b0, dividend: '0, divisor: '0, rem_init: '0};
    unique case (state)
      S_SQ1: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(dabs);
        div_req.divisor  = 32'(k);
      end
      S_DIV1: begin
        div_req.start    = div_done;
        div_req.dividend = sq;
        div_req.divisor  = 32'(k);
      end
      S_END: begin
        div_req.start    = last_r && !zero_seen && (sample_count >= CNT_W'(2));
        div_req.dividend = sum_sq_dev;
        div_req.divisor  = 32'(sample_count - 1'b1);
      end
      S_CHK: begin
        div_req.start    = (time_step != '0) && (var_q[63:16] < {16'b0, time_step});
        div_req.dividend = {var_q[15:0], 48'b0};
        div_req.divisor  = time_step;
        div_req.rem_init = var_q[47:16];
      end
      default: ;
    endcase
  end

  // Sequencer and series state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      sample_count <= '0;
      zero_seen    <= 1'b0;
      mean_return  <= '0;
      sum_sq_dev   <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (pop && res_valid) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (sample_count >= CNT_W'(MAX_SAMPLES)) begin
              state <= S_END;
            end else if (zero_seen || q_item.is_zero) begin
              zero_seen    <= 1'b1;
              sample_count <= sample_count + 1'b1;
              state        <= S_END;
            end else begin
              sample_count <= sample_count + 1'b1;
              cnt          <= '0;
              state        <= S_LOG;
            end
          end
        end
        S_LOG: begin
          cnt <= cnt + 1'b1;
          if (cnt == 5'd31) state <= S_LOGD;
        end
        S_LOGD:  state <= (k == '0) ? S_END : S_RET1;
        S_RET1:  state <= S_RET2;
        S_RET2:  state <= S_DELTA;
        S_DELTA: begin
          if (k == CNT_W'(1)) begin
            mean_return <= r;
            sum_sq_dev  <= '0;
            state       <= S_END;
          end else begin
            state <= S_SQ1;
          end
        end
        S_SQ1:   state <= S_SQ2;
        S_SQ2:   state <= S_DIV1;
        S_DIV1:  if (div_done) state <= S_DIV2;
        S_DIV2: begin
          if (div_done) begin
            mean_return <= dsign ? mean_return - step[39:0] : mean_return + step[39:0];
            sum_sq_dev  <= sum_ext[64] ? '1 : sum_ext[63:0];
            state       <= S_END;
          end
        end
        S_END: begin
          if (!last_r) state <= S_IDLE;
          else if (div_req.start) state <= S_VAR;
          else state <= S_OUT;
        end
        S_VAR:   if (div_done) state <= S_CHK;
        S_CHK:   state <= div_req.start ? S_RAD : S_OUT;
        S_RAD: begin
          if (div_done) begin
            cnt   <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          cnt <= cnt + 1'b1;
          if (cnt == 5'd31) state <= S_OUT;
        end
        S_OUT: begin
          if (out_fire) begin
            res_valid    <= 1'b1;
            sample_count <= '0;
            zero_seen    <= 1'b0;
            mean_return  <= '0;
            sum_sq_dev   <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        k        <= sample_count;
        last_r   <= q_item.last;
        log_e    <= lead;
        log_frac <= '0;
        m        <= m_init;
      end
      S_LOG: begin
        log_frac <= {log_frac[30:0], mt[32]};
        m        <= mt[32] ? mt[32:1] : mt[31:0];
      end
      S_LOGD: begin
        prev_log <= cur_log;
        dneg     <= d[37];
        dmag     <= d[37] ? 37'(-d) : d[36:0];
      end
      S_RET1:  prod <= 64'(dmag[31:0]) * 64'(LN2_Q32);
      S_RET2:  r <= dneg ? 40'(-rmag) : 40'(rmag);
      S_DELTA: begin
        dsign <= delta[40];
        dabs  <= delta[40] ? 41'(-delta) : delta;
      end
      S_SQ1: begin
        p0 <= 64'(dabs[31:0]) * 64'(dabs[31:0]);
        p1 <= 41'(dabs[40:32]) * 41'(dabs[31:0]);
        p2 <= 18'(dabs[40:32]) * 18'(dabs[40:32]);
      end
      S_SQ2:  sq <= {14'b0, p2, 32'b0} + {22'b0, p1, 1'b0} + {32'b0, p0[63:32]};
      S_DIV1: if (div_done) step <= div_quot[40:0];
      S_END: begin
        vol <= '0;
        if (zero_seen) st <= ST_ZERO;
        else if (sample_count < CNT_W'(2)) st <= ST_SHORT;
        else st <= ST_OK;
      end
      S_VAR:  if (div_done) var_q <= div_quot;
      S_CHK:  if (!div_req.start) vol <= '1;
      S_RAD: begin
        rad  <= div_quot;
        srem <= '0;
        root <= '0;
      end
      S_SQRT: begin
        srem <= s_ge ? s_sh - s_trial : s_sh;
        rad  <= {rad[61:0], 2'b00};
        root <= root_next;
        if (cnt == 5'd31) vol <= root_next;
      end
      S_OUT: if (out_fire) res <= '{volatility: vol, status: st};
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) div_req.start |-> !div_busy)
    else $error("divider started while busy");
  assert property (@(posedge clk) disable iff (rst) sample_count <= CNT_W'(MAX_SAMPLES))
    else $error("price count beyond limit");
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != ST_OK) |-> res.volatility == '0)
    else $error("failed series gave a volatility");
  assert property (@(posedge clk) disable iff (rst) out_fire |=> sample_count == '0)
    else $error("series not cleared after result");

endmodule
`default_nettype wire

// ===== sv/historical_log_return_volatility_core.sv =====
// Historical log-return volatility: top level with configuration port.
// Depends on hlrv_pkg, hlrv_front, hlrv_div and hlrv_engine.
//
// Usage: prices (unsigned Q16.16) enter as items through push/full, one series
// at a time; the item with last set closes the series. One result per series
// (volatility Q8.24 and status) leaves through empty/pop, oldest first.
// A four-item queue sits in front of the engine and a result register after
// it, so the sender keeps pushing while a result waits to be popped.
// A price gets its log2 (one squaring a cycle), then return and square
// arithmetic and two runs of the shared divider for the Welford update; the
// first two prices of a series and zero prices skip the divider runs. The
// last item of a series with status OK adds the variance divide and, unless
// the result would overflow, the time step divide and the square root. The
// shared divider sets the pace. The time step register sits at byte address
// 0; the user must write it only while the block is idle, which the block
// does not enforce. Reset clears the series and loads the default time step.
// A stalled receiver holds the result; the engine then waits at the next
// result while the front queue keeps filling.
`default_nettype none
module historical_log_return_volatility_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire hlrv_pkg::price_item_t item,
  output logic                       empty,
  input  wire logic                  pop,
  output hlrv_pkg::vol_result_t      result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import hlrv_pkg::*;

  logic        [31:0] time_step;
  logic               q_valid;
  front_item_t        q_item;
  logic               q_pop;
  div_req_t           div_req;
  logic               div_busy;
  logic               div_done;
  logic        [63:0] div_quot;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIME_STEP) ? time_step : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TIME_STEP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_TIME_STEP) begin
      time_step <= pwdata;
    end
  end

  hlrv_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  hlrv_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .done (div_done),
    .quot (div_quot)
  );

  hlrv_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .time_step (time_step),
    .div_req   (div_req),
    .div_busy  (div_busy),
    .div_done  (div_done),
    .div_quot  (div_quot),
    .empty     (empty),
    .result    (result),
    .pop       (pop)
  );

endmodule
`default_nettype wire
